/* hdl/wcfc_pkg.sv */
`default_nettype none

package wcfc_pkg;

	localparam int MAX_WORDS     = 32;
	localparam int DATA_PER_WORD = 2;
	localparam int WORD_BYTES    = DATA_PER_WORD + 1;

	localparam int BYTE_W = 8;
	localparam int WC_W   = 6;
	localparam int POS_W  = 2;
	localparam int REM_W  = $clog2(WORD_BYTES * MAX_WORDS + 1);

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_MATCH    = 2'd1,
		KIND_MISMATCH = 2'd2,
		KIND_DISCARD  = 2'd3
	} byte_kind_t;

endpackage

`default_nettype wire

/* hdl/wcfc_crc.sv */
`default_nettype none

module wcfc_crc
	import wcfc_pkg::*;
(
	input  wire logic [BYTE_W-1:0] crc_in,
	input  wire logic [BYTE_W-1:0] data,
	output logic      [BYTE_W-1:0] crc_out
);

	// msb-first crc-8, one bit per step, unrolled
	always_comb begin
		logic [BYTE_W-1:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

`default_nettype wire

/* hdl/word_crc_frame_checker.sv */
// channel | handshake             | payload
// rx      | rx_valid / rx_stall   | rx_byte, frame_start, word_count
// res     | res_valid / res_stall | data_byte, byte_kind, last
//
// one byte in per cycle, one byte out per cycle while res_stall is low; a byte
// passes the input register, then the result register after the crc and count update
// arst_n clears valids and the frame state (crc 0xff, position, count, fail)
// res_stall holds the result register; rx_stall rises only when both the
// input register and the result register are full and the result is stalled
`default_nettype none

module word_crc_frame_checker
	import wcfc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rx_valid,
	output logic                   rx_stall,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic              frame_start,
	input  wire logic [WC_W-1:0]   word_count,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic      [BYTE_W-1:0] data_byte,
	output logic      [1:0]        byte_kind,
	output logic                   last
);

	localparam logic [WC_W:0]  MAX_WORDS_V = (WC_W + 1)'(MAX_WORDS);
	localparam logic [REM_W-1:0] REM_MAX   = REM_W'(WORD_BYTES * MAX_WORDS);

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;
	logic [WC_W-1:0]   wc_s1;

	// result register
	logic              valid_s2;
	logic [BYTE_W-1:0] data_s2;
	byte_kind_t        kind_s2;
	logic              last_s2;

	// frame state
	logic [BYTE_W-1:0] crc_q;
	logic [POS_W-1:0]  pos_q;
	logic [REM_W-1:0]  rem_q;
	logic              failed_q;

	logic              adv;
	logic              rx_take;

	logic [WC_W:0]     wc_clamp;
	logic [WC_W+2:0]   frame_bytes;
	logic [BYTE_W-1:0] crc_eff;
	logic [POS_W-1:0]  pos_eff;
	logic [REM_W-1:0]  rem_eff;
	logic              failed_eff;
	logic [BYTE_W-1:0] crc_upd;

	logic [BYTE_W-1:0] crc_nxt;
	logic [POS_W-1:0]  pos_nxt;
	logic [REM_W-1:0]  rem_nxt;
	logic              failed_nxt;
	byte_kind_t        kind_nxt;
	logic              last_nxt;

	assign adv      = !valid_s2 || !res_stall;
	assign rx_stall = valid_s1 && !adv;
	assign rx_take  = rx_valid && !rx_stall;

	wcfc_crc u_crc (
		.crc_in  (crc_eff),
		.data    (byte_s1),
		.crc_out (crc_upd)
	);

	always_comb begin
		wc_clamp = {1'b0, wc_s1};
		if (wc_clamp == '0) begin
			wc_clamp = (WC_W + 1)'(1);
		end
		if (wc_clamp > MAX_WORDS_V) begin
			wc_clamp = MAX_WORDS_V;
		end
		frame_bytes = {2'b00, wc_clamp} + {1'b0, wc_clamp, 1'b0};

		if (start_s1) begin
			crc_eff    = CRC_INIT;
			pos_eff    = '0;
			rem_eff    = REM_W'(frame_bytes);
			failed_eff = 1'b0;
		end else begin
			crc_eff    = crc_q;
			pos_eff    = pos_q;
			rem_eff    = rem_q;
			failed_eff = failed_q;
		end

		crc_nxt    = crc_eff;
		pos_nxt    = pos_eff;
		rem_nxt    = rem_eff;
		failed_nxt = failed_eff;
		kind_nxt   = KIND_DISCARD;
		last_nxt   = 1'b0;

		// no open frame: discard and leave state alone
		if (rem_eff != '0) begin
			if (failed_eff) begin
				kind_nxt = KIND_DISCARD;
			end else if (pos_eff < POS_W'(DATA_PER_WORD)) begin
				crc_nxt  = crc_upd;
				pos_nxt  = pos_eff + POS_W'(1);
				kind_nxt = KIND_DATA;
			end else begin
				if (byte_s1 == crc_eff) begin
					kind_nxt = KIND_MATCH;
				end else begin
					kind_nxt   = KIND_MISMATCH;
					failed_nxt = 1'b1;
				end
				crc_nxt = CRC_INIT;
				pos_nxt = '0;
			end
			rem_nxt  = rem_eff - REM_W'(1);
			last_nxt = (rem_nxt == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
			wc_s1    <= word_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			crc_q    <= CRC_INIT;
			pos_q    <= '0;
			rem_q    <= '0;
			failed_q <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				crc_q    <= crc_nxt;
				pos_q    <= pos_nxt;
				rem_q    <= rem_nxt;
				failed_q <= failed_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			data_s2 <= byte_s1;
			kind_s2 <= kind_nxt;
			last_s2 <= last_nxt;
		end
	end

	assign res_valid = valid_s2;
	assign data_byte = data_s2;
	assign byte_kind = kind_s2;
	assign last      = last_s2;

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(DATA_PER_WORD))
		else $error("word position out of range");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= REM_MAX)
		else $error("byte count above frame maximum");

	a_mismatch_fails: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && kind_nxt == KIND_MISMATCH |=> failed_q)
		else $error("mismatch did not fail the frame");

	a_failed_discards: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && failed_q && !start_s1 |-> kind_nxt == KIND_DISCARD)
		else $error("byte of failed frame not discarded");

endmodule

`default_nettype wire
